@@ design/tlg_pkg.sv @@
// shared types, constants and helpers of the turtle line generator
`default_nettype none
package tlg_pkg;

  localparam int HeadW = 25;
  localparam int PosW  = 32;
  localparam int ColW  = 24;
  localparam int CordW = 34;
  localparam int ZW    = 27;
  localparam int CordSteps = 16;

  localparam logic [HeadW-1:0] FULL_TURN    = 25'd23592960;
  localparam logic [HeadW-1:0] HALF_TURN    = 25'd11796480;
  localparam logic [HeadW-1:0] QUARTER_TURN = 25'd5898240;
  localparam logic signed [CordW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_OPEN  = 8'h28;
  localparam logic [7:0] SYM_CLOSE = 8'h29;

  localparam logic [1:0] ST_SEG   = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_TURN  = 2'd1;
  localparam logic [1:0] REG_COLOR = 2'd2;

  typedef enum logic [2:0] {
    OP_STEP, OP_PLUS, OP_MINUS, OP_OPEN, OP_CLOSE, OP_BAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic draws;
    logic restart;
  } qent_t;

  typedef struct packed {
    logic [HeadW-1:0] start_mod;
    logic [HeadW-1:0] turn_mod;
    logic [ColW-1:0]  color;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] x_start;
    logic signed [PosW-1:0] y_start;
    logic signed [PosW-1:0] x_end;
    logic signed [PosW-1:0] y_end;
    logic [ColW-1:0]        seg_color;
    logic [1:0]             status;
  } seg_t;

  // arctangent of 2^-i in Q6.16 degrees
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] r;
    unique case (i)
      4'd0:  r = 22'd2949120;
      4'd1:  r = 22'd1740967;
      4'd2:  r = 22'd919879;
      4'd3:  r = 22'd466945;
      4'd4:  r = 22'd234379;
      4'd5:  r = 22'd117304;
      4'd6:  r = 22'd58666;
      4'd7:  r = 22'd29335;
      4'd8:  r = 22'd14668;
      4'd9:  r = 22'd7334;
      4'd10: r = 22'd3667;
      4'd11: r = 22'd1833;
      4'd12: r = 22'd917;
      4'd13: r = 22'd458;
      4'd14: r = 22'd229;
      default: r = 22'd115;
    endcase
    return r;
  endfunction

  // reduce a value below twice a full turn into one turn
  function automatic logic [HeadW-1:0] wrap_turn(input logic [HeadW:0] v);
    logic [HeadW:0] d;
    d = v - {1'b0, FULL_TURN};
    return (v >= {1'b0, FULL_TURN}) ? d[HeadW-1:0] : v[HeadW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/tlg_if.sv @@
// channel interfaces: symbol items, segment items, configuration writes
`default_nettype none
interface tlg_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       in_alphabet;
  logic       draws;
  logic       restart;
  modport source(output valid, symbol, in_alphabet, draws, restart, input ready);
  modport sink(input valid, symbol, in_alphabet, draws, restart, output ready);
endinterface

interface tlg_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_start;
  logic signed [31:0] y_start;
  logic signed [31:0] x_end;
  logic signed [31:0] y_end;
  logic [23:0]        seg_color;
  logic [1:0]         status;
  modport source(output valid, x_start, y_start, x_end, y_end, seg_color, status,
                 input ready);
  modport sink(input valid, x_start, y_start, x_end, y_end, seg_color, status,
               output ready);
endinterface

interface tlg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [24:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/tlg_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/tlg_front.sv @@
// front end: classifies symbol items and queues them for the back end
`default_nettype none
module tlg_front
  import tlg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tlg_sym_if.sink    sym,
  output      logic  q_valid,
  output      qent_t q_data,
  input  wire logic  q_pop
);
  qent_t      slot [2];
  logic [1:0] count;
  qent_t      cls;
  logic       push;

  // classify the symbol, alphabet membership wins
  always_comb begin
    cls.draws   = sym.draws;
    cls.restart = sym.restart;
    if (sym.in_alphabet) begin
      cls.op = OP_STEP;
    end else begin
      unique case (sym.symbol)
        SYM_PLUS:  cls.op = OP_PLUS;
        SYM_MINUS: cls.op = OP_MINUS;
        SYM_OPEN:  cls.op = OP_OPEN;
        SYM_CLOSE: cls.op = OP_CLOSE;
        default:   cls.op = OP_BAD;
      endcase
    end
  end

  assign sym.ready = (count != 2'd2);
  assign push      = sym.valid && sym.ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = slot[0];

  // two entry queue, head in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
    if (q_pop && q_valid) begin
      slot[0] <= (count == 2'd2) ? slot[1] : cls;
      if (push) begin
        slot[1] <= cls;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot[0] <= cls;
      end else begin
        slot[1] <= cls;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/tlg_back.sv @@
// back end: turtle state, cordic sequencer, stack and output register
`default_nettype none
module tlg_back
  import tlg_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire qent_t q_data,
  output      logic  q_pop,
  tlg_seg_if.source  seg
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int SW = HeadW + 2 * PosW;
  localparam int PayW = 4 * PosW + ColW;
  localparam logic [LW-1:0] FULL_LEVEL = LW'(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CORDIC = 6'b000100,
    S_FINISH = 6'b001000,
    S_POP    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t                  state;
  qent_t                   cur;
  logic [HeadW-1:0]        heading;
  logic signed [PosW-1:0]  pos_x, pos_y;
  logic [LW-1:0]           level;
  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0]    cz;
  logic                    neg;
  logic [3:0]              cnt;
  seg_t                    res;
  seg_t                    ob;
  logic                    ovalid;
  logic                    out_load;

  logic                    ram_we;
  logic [SW-1:0]           ram_rdata;
  logic [LW-1:0]           level_dec;

  logic signed [ZW-1:0]    z0, z1;
  logic                    neg0;
  logic signed [CordW-1:0] xs, ys;
  logic signed [ZW-1:0]    at;
  logic signed [CordW-1:0] cr, sr, cv, sv;
  logic signed [CordW-1:0] sumx, sumy;
  logic signed [PosW-1:0]  nx, ny;

  assign level_dec = level - LW'(1);
  assign ram_we    = (state == S_DECODE) && (cur.op == OP_OPEN) && (level != FULL_LEVEL);

  tlg_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (level[AW-1:0]),
    .wdata ({heading, pos_x, pos_y}),
    .raddr (level_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // heading folded into plus or minus a quarter turn
  always_comb begin
    z0   = $signed({2'b00, heading});
    neg0 = 1'b0;
    if (heading > HALF_TURN) begin
      z0 = z0 - $signed({2'b00, FULL_TURN});
    end
    z1 = z0;
    if (z0 > $signed({2'b00, QUARTER_TURN})) begin
      z1   = z0 - $signed({2'b00, HALF_TURN});
      neg0 = 1'b1;
    end else if (z0 < -$signed({2'b00, QUARTER_TURN})) begin
      z1   = z0 + $signed({2'b00, HALF_TURN});
      neg0 = 1'b1;
    end
  end

  // one cordic micro-rotation
  always_comb begin
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    at = $signed({5'b0, atan_q16(cnt)});
  end

  // rounding, sign fix and saturating position update
  always_comb begin
    cr   = (cx + CordW'(8192)) >>> 14;
    sr   = (cy + CordW'(8192)) >>> 14;
    cv   = neg ? -cr : cr;
    sv   = neg ? -sr : sr;
    sumx = {{(CordW-PosW){pos_x[PosW-1]}}, pos_x} + cv;
    sumy = {{(CordW-PosW){pos_y[PosW-1]}}, pos_y} + sv;
    if (sumx[CordW-1:PosW-1] == '0 || sumx[CordW-1:PosW-1] == '1) begin
      nx = sumx[PosW-1:0];
    end else begin
      nx = sumx[CordW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    if (sumy[CordW-1:PosW-1] == '0 || sumy[CordW-1:PosW-1] == '1) begin
      ny = sumy[PosW-1:0];
    end else begin
      ny = sumy[CordW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
  end

  assign q_pop    = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!ovalid || seg.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      heading <= '0;
      pos_x   <= '0;
      pos_y   <= '0;
      level   <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (seg.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            if (q_data.restart) begin
              heading <= cfg.start_mod;
              pos_x   <= '0;
              pos_y   <= '0;
              level   <= '0;
            end
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cur.op)
            OP_STEP: begin
              cx    <= CORDIC_GAIN;
              cy    <= '0;
              cz    <= z1;
              neg   <= neg0;
              cnt   <= '0;
              state <= S_CORDIC;
            end
            OP_PLUS: begin
              heading <= wrap_turn({1'b0, heading} + {1'b0, cfg.turn_mod});
              state   <= S_IDLE;
            end
            OP_MINUS: begin
              heading <= wrap_turn({1'b0, heading} + {1'b0, FULL_TURN}
                                   - {1'b0, cfg.turn_mod});
              state   <= S_IDLE;
            end
            OP_OPEN: begin
              if (level == FULL_LEVEL) begin
                res   <= {PayW'(0), ST_FULL};
                state <= S_OUT;
              end else begin
                level <= level + LW'(1);
                state <= S_IDLE;
              end
            end
            OP_CLOSE: begin
              if (level == '0) begin
                res   <= {PayW'(0), ST_EMPTY};
                state <= S_OUT;
              end else begin
                level <= level_dec;
                state <= S_POP;
              end
            end
            default: begin
              res   <= {PayW'(0), ST_BAD};
              state <= S_OUT;
            end
          endcase
        end
        S_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'(CordSteps - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          pos_x <= nx;
          pos_y <= ny;
          if (nx < pos_x) begin
            res <= {nx, ny, pos_x, pos_y, cfg.color, ST_SEG};
          end else begin
            res <= {pos_x, pos_y, nx, ny, cfg.color, ST_SEG};
          end
          state <= cur.draws ? S_OUT : S_IDLE;
        end
        S_POP: begin
          {heading, pos_x, pos_y} <= ram_rdata;
          state <= S_IDLE;
        end
        S_OUT: begin
          if (out_load) begin
            ob    <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign seg.valid     = ovalid;
  assign seg.x_start   = ob.x_start;
  assign seg.y_start   = ob.y_start;
  assign seg.x_end     = ob.x_end;
  assign seg.y_end     = ob.y_end;
  assign seg.seg_color = ob.seg_color;
  assign seg.status    = ob.status;
endmodule
`default_nettype wire

@@ design/turtle_line_generator_2d.sv @@
// top level of the 2d turtle line generator
// Channels: sym carries one symbol item of an expanded L-system string with
// its alphabet, draw and restart flags; seg carries one result item, either a
// segment (status 0, ends ordered by x) or an error report; cfg writes
// start_heading (index 0), turn_step (1) and line_color (2), always ready.
// A two entry queue decouples the symbol classifier from the executing back
// end, so symbols are taken while a result waits at the output register.
// In the back end a turn or push passes take and decode, a pop adds a stack
// read, an error adds the output load, and a step adds 16 cordic iterations on
// one shared shift-add unit, rounding and, with a segment, the output load.
// A new item is taken from the queue only after the back end has finished the
// last one; steps are the slowest, held by the cordic iteration loop.
// Reset clears position, heading, stack level, queue and output register;
// the stack memory needs no clearing pass. When the receiver holds seg.ready
// low the output register keeps its item, the back end stops at its next
// result and the queue fills, after which sym.ready drops.
`default_nettype none
module turtle_line_generator_2d
  import tlg_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  tlg_sym_if.sink   sym,
  tlg_seg_if.source seg,
  tlg_cfg_if.sink   cfg
);
  logic [HeadW-1:0] start_heading;
  logic [HeadW-1:0] turn_step;
  logic [ColW-1:0]  line_color;
  cfg_t             cfg_bus;
  logic             q_valid;
  qent_t            q_data;
  logic             q_pop;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_heading <= '0;
      turn_step     <= 25'd5898240;
      line_color    <= 24'hFFFFFF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START: start_heading <= cfg.data;
        REG_TURN:  turn_step     <= cfg.data;
        REG_COLOR: line_color    <= cfg.data[ColW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_bus.start_mod = wrap_turn({1'b0, start_heading});
  assign cfg_bus.turn_mod  = wrap_turn({1'b0, turn_step});
  assign cfg_bus.color     = line_color;

  tlg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .sym     (sym),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  tlg_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .seg     (seg)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.status != ST_SEG |-> seg.x_start == 0 && seg.seg_color == 0)
    else $error("error item carries nonzero payload");
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.status == ST_SEG |-> seg.x_start <= seg.x_end)
    else $error("segment ends not ordered by x");
  a_reset_out: assert property (@(posedge clk) rst |=> !seg.valid)
    else $error("output valid after reset");
`endif
endmodule
`default_nettype wire
